// ----- src/range_scan_collect_sort_core_assert.svh -----
// assertion macros shared by the core
`ifndef RANGE_SCAN_COLLECT_SORT_CORE_ASSERT_SVH
`define RANGE_SCAN_COLLECT_SORT_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RSCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rscs assertion failed");

// next-cycle implication, checked outside reset
`define RSCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rscs assertion failed");

`endif

// ----- src/rscs_pkg.sv -----
`timescale 1ns / 1ps

package rscs_pkg;

   localparam int DIST_W          = 10;
   localparam int ANGLE_IN_W      = 9;
   localparam int ANGLE_W         = 10;
   localparam int RECORDS_DEFAULT = 16;

   localparam logic [ANGLE_W-1:0] BACK_OFFSET = ANGLE_W'(180);
   localparam logic [DIST_W-1:0]  LIMIT_RESET = DIST_W'(75);

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]  distance;
   } record_type;

   // per-cycle command broadcast along the cell row
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

endpackage

// ----- src/rscs_if.sv -----
`timescale 1ns / 1ps

interface rscs_req_if;
   logic                              valid;
   logic                              ready;
   logic [rscs_pkg::DIST_W-1:0]       range_distance;
   logic [rscs_pkg::ANGLE_IN_W-1:0]   scan_angle;
   logic                              from_back_sensor;

   modport source (output valid, range_distance, scan_angle, from_back_sensor,
                   input ready);
   modport sink   (input valid, range_distance, scan_angle, from_back_sensor,
                   output ready);
endinterface

interface rscs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rscs_pkg::DIST_W-1:0]   sorted_distance;
   logic [rscs_pkg::ANGLE_W-1:0]  object_angle;
   logic                          last_record;

   modport source (output valid, sorted_distance, object_angle, last_record,
                   input ready);
   modport sink   (input valid, sorted_distance, object_angle, last_record,
                   output ready);
endinterface

interface rscs_csr_if;
   logic                        valid;
   logic                        ready;
   logic [rscs_pkg::DIST_W-1:0] distance_limit;

   modport source (output valid, distance_limit, input ready);
   modport sink   (input valid, distance_limit, output ready);
endinterface

// ----- src/rscs_cell.sv -----
`timescale 1ns / 1ps

module rscs_cell (
   input  logic                   clock,
   input  rscs_pkg::cell_ctrl_type ctrl,
   input  rscs_pkg::record_type   new_rec,
   input  logic                   occupied,
   input  logic                   left_keep,
   input  rscs_pkg::record_type   left_rec,
   input  rscs_pkg::record_type   right_rec,
   output logic                   keep,
   output rscs_pkg::record_type   rec
);

   rscs_pkg::record_type rec_ff;
   rscs_pkg::record_type rec_in;

   // equal distances stay ahead of the newcomer
   assign keep = occupied && (rec_ff.distance >= new_rec.distance);
   assign rec  = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.shift) begin
         rec_in = right_rec;
      end else if (ctrl.insert && !keep) begin
         rec_in = left_keep ? new_rec : left_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// ----- src/range_scan_collect_sort_core.sv -----
`timescale 1ns / 1ps
// collection: one sample beat per cycle, each kept sample is placed in sorted order as it is accepted
// drain: after RECORDS kept samples, RECORDS result beats, one per cycle when rsp is ready
// the cell row shifts once per result beat
// first result appears the cycle after the beat that completes the set
// synchronous active-high reset: limit back to 75, count cleared, collecting

module range_scan_collect_sort_core #(
   parameter int RECORDS = rscs_pkg::RECORDS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rscs_req_if.sink   req,
   rscs_rsp_if.source rsp,
   rscs_csr_if.sink   csr
);

`include "range_scan_collect_sort_core_assert.svh"

   localparam int CNT_W = $clog2(RECORDS + 1);

   // control state
   rscs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    kept_count_ff, kept_count_in;
   logic [rscs_pkg::DIST_W-1:0] limit_ff;

   // handshakes
   logic req_beat;
   logic rsp_beat;
   logic sample_kept;
   logic set_full;

   // cell row wiring
   rscs_pkg::record_type    new_rec;
   rscs_pkg::cell_ctrl_type ctrl;
   rscs_pkg::record_type    cell_rec  [RECORDS];
   logic [RECORDS-1:0]      cell_keep;
   logic [RECORDS-1:0]      cell_occ;

   // csr write channel never stalls
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= rscs_pkg::LIMIT_RESET;
      end else if (csr.valid && csr.ready) begin
         limit_ff <= csr.distance_limit;
      end
   end

   assign req_beat    = req.valid && req.ready;
   assign rsp_beat    = rsp.valid && rsp.ready;
   assign sample_kept = req_beat && (req.range_distance < limit_ff);
   assign set_full    = sample_kept && (kept_count_ff == CNT_W'(RECORDS - 1));

   // stored angle: back sensor samples are turned round by half a circle
   assign new_rec.distance = req.range_distance;
   assign new_rec.angle    = rscs_pkg::ANGLE_W'(req.scan_angle)
                           + (req.from_back_sensor ? rscs_pkg::BACK_OFFSET
                                                   : '0);

   assign ctrl.insert = sample_kept;
   assign ctrl.shift  = rsp_beat;

   // next state
   always_comb begin
      state_in      = state_ff;
      kept_count_in = kept_count_ff;
      case (state_ff)
         rscs_pkg::ST_COLLECT: begin
            if (sample_kept) begin
               kept_count_in = kept_count_ff + CNT_W'(1);
            end
            if (set_full) begin
               state_in = rscs_pkg::ST_DRAIN;
            end
         end
         rscs_pkg::ST_DRAIN: begin
            // the count doubles as the number of records still to send
            if (rsp_beat) begin
               kept_count_in = kept_count_ff - CNT_W'(1);
               if (kept_count_ff == CNT_W'(1)) begin
                  state_in = rscs_pkg::ST_COLLECT;
               end
            end
         end
         default: begin
            state_in      = rscs_pkg::ST_COLLECT;
            kept_count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rscs_pkg::ST_COLLECT;
         kept_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         kept_count_ff <= kept_count_in;
      end
   end

   // outputs
   always_comb begin
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         rscs_pkg::ST_COLLECT: req.ready = 1'b1;
         rscs_pkg::ST_DRAIN:   rsp.valid = 1'b1;
         default: begin
            req.ready = 1'b0;
            rsp.valid = 1'b0;
         end
      endcase
   end

   // head of the row is always the largest remaining distance
   assign rsp.sorted_distance = cell_rec[0].distance;
   assign rsp.object_angle    = cell_rec[0].angle;
   assign rsp.last_record     = (kept_count_ff == CNT_W'(1));

   // row of sorting cells: cell i holds the i-th largest record of the set
   for (genvar i = 0; i < RECORDS; i++) begin : g_cell
      rscs_pkg::record_type left_rec;
      rscs_pkg::record_type right_rec;
      logic                 left_keep;

      // only cells below the fill count hold records of the current set
      assign cell_occ[i] = (CNT_W'(i) < kept_count_ff);

      if (i == 0) begin : g_head
         assign left_rec  = new_rec;
         assign left_keep = 1'b1;
      end else begin : g_body
         assign left_rec  = cell_rec[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == RECORDS - 1) begin : g_tail
         assign right_rec = new_rec;
      end else begin : g_inner
         assign right_rec = cell_rec[i+1];
      end

      rscs_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_rec   (new_rec),
         .occupied  (cell_occ[i]),
         .left_keep (left_keep),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .keep      (cell_keep[i]),
         .rec       (cell_rec[i])
      );
   end

   // the fill count never passes the set size
   `RSCS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, kept_count_ff <= CNT_W'(RECORDS))

   // the sample that completes a set starts the drain with a full count
   `RSCS_ASSERT_NEXT(a_full_drains, clock, reset, set_full, (state_ff == rscs_pkg::ST_DRAIN) && (kept_count_ff == CNT_W'(RECORDS)))

   // after the final record the block collects a fresh set from zero
   `RSCS_ASSERT_NEXT(a_last_restarts, clock, reset, rsp_beat && rsp.last_record, (state_ff == rscs_pkg::ST_COLLECT) && (kept_count_ff == '0))

   // results are only offered while records remain
   `RSCS_ASSERT_NOW(a_drain_nonempty, clock, reset, rsp.valid, cell_occ[0])

endmodule

// ----- tb/sv/range_scan_collect_sort_core_tb.sv -----
`timescale 1ns / 1ps

module range_scan_collect_sort_core_tb;

   localparam int RECORDS       = rscs_pkg::RECORDS_DEFAULT;
   localparam int DIST_W        = rscs_pkg::DIST_W;
   localparam int ANGLE_IN_W    = rscs_pkg::ANGLE_IN_W;
   localparam int ANGLE_W       = rscs_pkg::ANGLE_W;
   localparam int SETTLE_CYCLES = 8;          // insert of a kept beat is done well within this
   localparam int END_CYCLES    = 2 * RECORDS;
   localparam int CYCLE_LIMIT   = 400000;

   // one expected beat on the sorted result channel
   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic [ANGLE_W-1:0] angle;
      logic               is_last;
   } sorted_record_type;

   // how the result side throttles ready
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_BURSTY
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   rscs_req_if req_bus ();
   rscs_rsp_if rsp_bus ();
   rscs_csr_if csr_bus ();

   // predictor state: our own copy of limit, load-order store and fill count
   logic [DIST_W-1:0]    limit_model = rscs_pkg::LIMIT_RESET;
   rscs_pkg::record_type load_store [RECORDS];
   int                   fill_count = 0;

   // sorted records still owed by the block, oldest first
   sorted_record_type sorted_run_q [$];

   int                errors          = 0;
   int                samples_sent    = 0;
   int                samples_kept    = 0;
   int                records_checked = 0;
   int                limit_writes    = 0;
   int                cycle_count     = 0;
   int                burst_left      = 0;

   int unsigned       rx_tick  = 0;
   int unsigned       rx_hold  = 0;
   logic              rx_level = 1'b1;
   rx_mode_type       rx_mode;

   range_scan_collect_sort_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // 10 ns period, high then low
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor: file one accepted sample; on a full set queue the stable descending run
   task automatic collect_sample(input logic [DIST_W-1:0] sample_dist,
                                 input logic [ANGLE_IN_W-1:0] angle,
                                 input logic from_back);
      rscs_pkg::record_type run [RECORDS];
      rscs_pkg::record_type cur;
      sorted_record_type    owed;
      int                   i;
      int                   j;
      if (sample_dist >= limit_model) begin
         return;                              // rejected beat: no state change
      end
      samples_kept++;
      cur.distance = sample_dist;
      cur.angle    = ANGLE_W'(angle)
                   + (from_back ? rscs_pkg::BACK_OFFSET : ANGLE_W'(0));
      load_store[fill_count] = cur;
      fill_count++;
      if (fill_count < RECORDS) begin
         return;
      end
      run = load_store;
      // insertion sort, strict compare keeps load order on equal distances
      for (i = 1; i < RECORDS; i++) begin
         cur = run[i];
         j   = i;
         while (j > 0 && run[j-1].distance < cur.distance) begin
            run[j] = run[j-1];
            j--;
         end
         run[j] = cur;
      end
      for (i = 0; i < RECORDS; i++) begin
         owed.distance = run[i].distance;
         owed.angle    = run[i].angle;
         owed.is_last  = (i == RECORDS - 1);
         sorted_run_q.push_back(owed);
      end
      fill_count = 0;
   endtask

   // monitor: every handshake sampled at the rising edge
   always @(posedge clock) begin
      sorted_record_type owed;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            limit_model = csr_bus.distance_limit;
         end
         if (req_bus.valid && req_bus.ready) begin
            collect_sample(req_bus.range_distance, req_bus.scan_angle,
                           req_bus.from_back_sensor);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sorted_run_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected record beat, expected none, actual %0d %0d %0b",
                        $time, rsp_bus.sorted_distance, rsp_bus.object_angle,
                        rsp_bus.last_record);
            end else begin
               owed = sorted_run_q.pop_front();
               records_checked++;
               if (rsp_bus.sorted_distance !== owed.distance) begin
                  errors++;
                  $display("%0t: sorted_distance expected %0d, actual %0d",
                           $time, owed.distance, rsp_bus.sorted_distance);
               end
               if (rsp_bus.object_angle !== owed.angle) begin
                  errors++;
                  $display("%0t: object_angle expected %0d, actual %0d",
                           $time, owed.angle, rsp_bus.object_angle);
               end
               if (rsp_bus.last_record !== owed.is_last) begin
                  errors++;
                  $display("%0t: last_record expected %0b, actual %0b",
                           $time, owed.is_last, rsp_bus.last_record);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side ready: mode taken from bits 9:8 of the tick count, bursty mode holds ready for random spans
   always @(negedge clock) begin
      rx_tick++;
      rx_mode = rx_mode_type'(rx_tick[9:8]);
      case (rx_mode)
         RX_ALWAYS: begin
            rsp_bus.ready <= 1'b1;
         end
         RX_COIN: begin
            rsp_bus.ready <= 1'($urandom_range(0, 1));
         end
         RX_SPARSE: begin
            rsp_bus.ready <= (rx_tick[1:0] == 2'd0);
         end
         default: begin
            if (rx_hold == 0) begin
               rx_hold  = $urandom_range(1, 8);
               rx_level = !rx_level;
            end
            rx_hold--;
            rsp_bus.ready <= rx_level;
         end
      endcase
   end

   // one sample beat; bursts of random length with random gaps, some gaps empty
   task automatic send_sample(input logic [DIST_W-1:0] sample_dist,
                              input logic [ANGLE_IN_W-1:0] angle,
                              input logic from_back);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock) req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid            <= 1'b1;
      req_bus.range_distance   <= sample_dist;
      req_bus.scan_angle       <= angle;
      req_bus.from_back_sensor <= from_back;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
   endtask

   // stop sending, wait for every owed record, then let a pending insert finish
   task automatic wait_drained();
      @(negedge clock) req_bus.valid <= 1'b0;
      burst_left = 0;
      while (sorted_run_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register beat, only issued while the block is idle
   task automatic write_limit(input logic [DIST_W-1:0] value);
      @(negedge clock);
      csr_bus.valid          <= 1'b1;
      csr_bus.distance_limit <= value;
      do @(posedge clock); while (!csr_bus.ready);
      limit_writes++;
      @(negedge clock) csr_bus.valid <= 1'b0;
   endtask

   // reset limit: just below, at and far above it
   task automatic test_default_limit();
      send_sample(10'd74, 9'd10, 1'b0);
      send_sample(10'd75, 9'd20, 1'b1);
      send_sample(10'd1023, 9'd30, 1'b0);
      send_sample(10'd0, 9'd40, 1'b1);
      wait_drained();
   endtask

   // widest limit, field extremes, angles past 359, ties; completes the first set
   task automatic test_full_range_set();
      write_limit(10'd1023);
      send_sample(10'd1022, 9'd0, 1'b0);
      send_sample(10'd1023, 9'd5, 1'b0);     // at the limit, dropped
      send_sample(10'd0, 9'd359, 1'b1);
      send_sample(10'd500, 9'd511, 1'b1);    // largest stored angle
      send_sample(10'd500, 9'd511, 1'b0);
      send_sample(10'd500, 9'd0, 1'b1);
      send_sample(10'd1, 9'd1, 1'b0);
      send_sample(10'd512, 9'd256, 1'b1);
      send_sample(10'd341, 9'd170, 1'b0);
      send_sample(10'd682, 9'd341, 1'b1);
      send_sample(10'd74, 9'd100, 1'b0);     // ties with a beat from the reset test
      send_sample(10'd0, 9'd0, 1'b0);
      send_sample(10'd1022, 9'd1, 1'b1);
      send_sample(10'd999, 9'd300, 1'b0);
      send_sample(10'd3, 9'd45, 1'b1);
      wait_drained();
   endtask

   // zero limit rejects everything, distance 0 included
   task automatic test_zero_limit();
      write_limit(10'd0);
      send_sample(10'd0, 9'd0, 1'b0);
      send_sample(10'd1023, 9'd511, 1'b1);
      send_sample(10'd500, 9'd200, 1'b0);
      wait_drained();
   endtask

   // random scans over several limits; mostly kept beats, some at or above the limit as noise
   task automatic test_random_scans();
      int unsigned limits [7];
      int unsigned counts [7];
      int unsigned lim;
      int unsigned sample_dist;
      int unsigned angle;
      int          p;
      int          k;
      limits = '{1023, 512, 2, 0, 1, 0, 75};
      counts = '{110, 70, 60, 80, 40, 12, 48};
      limits[3] = $urandom_range(3, 1022);
      for (p = 0; p < 7; p++) begin
         lim = limits[p];
         wait_drained();
         write_limit(lim[DIST_W-1:0]);
         for (k = 0; k < counts[p]; k++) begin
            if (lim == 0 || $urandom_range(0, 4) == 0) begin
               sample_dist = $urandom_range(lim, 1023);
            end else begin
               sample_dist = $urandom_range(0, lim - 1);
            end
            // mostly real scan angles, a quarter over the whole 9-bit field
            angle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, 359);
            send_sample(sample_dist[DIST_W-1:0], angle[ANGLE_IN_W-1:0],
                        1'($urandom_range(0, 1)));
         end
      end
      wait_drained();
   endtask

   initial begin
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.range_distance   = '0;
      req_bus.scan_angle       = '0;
      req_bus.from_back_sensor = 1'b0;
      csr_bus.valid            = 1'b0;
      csr_bus.distance_limit   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_default_limit();
      test_full_range_set();
      test_zero_limit();
      test_random_scans();

      // tail: nothing owed, give the block time to show any stray beat
      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (sorted_run_q.size() != 0) begin
         errors++;
         $display("%0t: records left over, expected 0, actual %0d",
                  $time, sorted_run_q.size());
      end
      $display("run covered %0d sample beats, %0d kept, %0d sorted sets of %0d records",
               samples_sent, samples_kept, records_checked / RECORDS, RECORDS);
      $display("distance limit written %0d times, from 0 to 1023", limit_writes);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
